FILE: rtl/core/text_terminal_cell_writer_top_defines.svh
// ----------------------------------------------------------------------------
// text_terminal_cell_writer_top_defines
// Assertion macros used by the terminal cell writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CELL_WRITER_TOP_DEFINES_SVH
`define TEXT_TERMINAL_CELL_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TTCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttcw: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TTCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttcw: next-cycle check failed");

`endif

FILE: rtl/core/ttcw_pkg.sv
// ----------------------------------------------------------------------------
// ttcw_pkg
// Field widths, operation codes and character codes of the terminal cell writer.
// ----------------------------------------------------------------------------
package ttcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 8;
  localparam int CELL_W      = CHAR_W + COLOR_W;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [CELL_W-1:0] cell_t;

  localparam op_t OP_PUT   = 2'd0;
  localparam op_t OP_CLEAR = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  localparam char_t CH_BACKSPACE = 8'h08;
  localparam char_t CH_NEWLINE   = 8'h0A;
  localparam char_t CH_RETURN    = 8'h0D;
  localparam char_t CH_SPACE     = 8'h20;

  localparam color_t COLOR_RESET = 8'h07;
  localparam cell_t  CELL_RESET  = {COLOR_RESET, CH_SPACE};

endpackage

FILE: rtl/core/text_terminal_cell_writer_top.sv
// ----------------------------------------------------------------------------
// text_terminal_cell_writer_top
// Text screen of ROWS x COLUMNS cells with a cursor: put, clear and read.
// ----------------------------------------------------------------------------
//  channel | ports                                          | beat
//  --------+------------------------------------------------+--------------------
//  in      | in_valid/in_ready, in_operation, in_char_code, | one operation
//          | in_read_row, in_read_column                    |
//  out     | out_valid/out_ready, out_cell_data,            | one result per op
//          | out_cursor_row, out_cursor_column              |
//  cfg     | cfg_valid/cfg_ready, cfg_text_color            | attribute byte
//
// Put without scroll, unused op code, out-of-range read: S_EXEC, then S_RESP,
// which sets out_valid when the output is free; in-range read adds S_RDWAIT.
// Scroll runs S_COPY, S_DRAIN, then S_BLANK on the last row; clear writes
// one cell per cycle in S_BLANK. After reset the memory is swept to blank
// cells with in_ready low; cfg beats are taken throughout.
// A new item is taken while a result waits; it stalls only at its own result.
// ----------------------------------------------------------------------------
`include "text_terminal_cell_writer_top_defines.svh"

module text_terminal_cell_writer_top #(
  parameter int COLUMNS = ttcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttcw_pkg::ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ttcw_pkg::OP_W-1:0]         in_operation,
  input  logic [ttcw_pkg::CHAR_W-1:0]       in_char_code,
  input  logic [ttcw_pkg::ROW_FIELD_W-1:0]  in_read_row,
  input  logic [ttcw_pkg::COL_FIELD_W-1:0]  in_read_column,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ttcw_pkg::CELL_W-1:0]       out_cell_data,
  output logic [ttcw_pkg::ROW_FIELD_W-1:0]  out_cursor_row,
  output logic [ttcw_pkg::COL_FIELD_W-1:0]  out_cursor_column,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ttcw_pkg::COLOR_W-1:0]      cfg_text_color
);

  import ttcw_pkg::*;

  localparam int DEPTH         = ROWS * COLUMNS;
  localparam int AW            = $clog2(DEPTH);
  localparam int RW            = $clog2(ROWS + 1);
  localparam int CW            = $clog2(COLUMNS + 1);
  localparam int LAST_CELL     = DEPTH - 1;
  localparam int COPY_LAST     = (ROWS - 1) * COLUMNS - 1;
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_BLANK  = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  color_t        color_r;
  cell_t         data_r, data_nxt;
  logic          wr_pend_r;
  logic [AW-1:0] wr_addr_r;

  op_t                    op_r;
  char_t                  ch_r;
  logic [ROW_FIELD_W-1:0] rr_r;
  logic [COL_FIELD_W-1:0] rc_r;

  logic          out_valid_r, out_valid_nxt;
  cell_t         out_cell_r;
  logic [RW-1:0] out_row_r;
  logic [CW-1:0] out_col_r;
  logic          out_load;

  // cell memory
  cell_t         mem [DEPTH];
  cell_t         mem_q_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  cell_t         mem_wdata;

  // put decode
  logic [RW-1:0] row_w;
  logic [CW-1:0] col_w;
  logic [CW-1:0] put_col;
  logic          put_we;
  char_t         put_char;
  logic          put_scroll;
  logic [AW-1:0] put_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;
  logic          out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    row_w    = cur_row_r;
    col_w    = cur_col_r;
    put_col  = cur_col_r;
    put_we   = 1'b0;
    put_char = ch_r;
    priority if (ch_r == CH_NEWLINE) begin
      col_w = '0;
      row_w = cur_row_r + RW'(1);
    end else if (ch_r == CH_RETURN) begin
      col_w = '0;
    end else if (ch_r == CH_BACKSPACE) begin
      if (cur_col_r != '0) begin
        col_w    = cur_col_r - CW'(1);
        put_col  = col_w;
        put_we   = 1'b1;
        put_char = CH_SPACE;
      end
    end else begin
      put_we = 1'b1;
      col_w  = cur_col_r + CW'(1);
    end
    // wrap at the end of a row
    if (col_w == CW'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + RW'(1);
    end
    put_scroll = (row_w == RW'(ROWS));
    if (put_scroll) begin
      row_w = RW'(ROWS - 1);
    end
  end

  assign put_addr    = AW'(cur_row_r) * AW'(COLUMNS) + AW'(put_col);
  assign rd_addr     = AW'(rr_r) * AW'(COLUMNS) + AW'(rc_r);
  assign rd_in_range = (int'(rr_r) < ROWS) && (int'(rc_r) < COLUMNS);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = {color_r, CH_SPACE};
    mem_re        = 1'b0;
    mem_raddr     = rd_addr;
    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = CELL_RESET;
        if (idx_r == AW'(LAST_CELL)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        data_nxt = '0;
        unique case (op_r)
          OP_PUT: begin
            mem_we      = put_we;
            mem_waddr   = put_addr;
            mem_wdata   = {color_r, put_char};
            cur_row_nxt = row_w;
            cur_col_nxt = col_w;
            if (put_scroll) begin
              idx_nxt   = '0;
              state_nxt = S_COPY;
            end else begin
              state_nxt = S_RESP;
            end
          end
          OP_CLEAR: begin
            cur_row_nxt = '0;
            cur_col_nxt = '0;
            idx_nxt     = '0;
            state_nxt   = S_BLANK;
          end
          OP_READ: begin
            if (rd_in_range) begin
              mem_re    = 1'b1;
              state_nxt = S_RDWAIT;
            end else begin
              state_nxt = S_RESP;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_RDWAIT: begin
        data_nxt  = mem_q_r;
        state_nxt = S_RESP;
      end
      S_COPY: begin
        // read one row below, write back the cell read last cycle
        mem_re    = 1'b1;
        mem_raddr = idx_r + AW'(COLUMNS);
        mem_we    = wr_pend_r;
        mem_waddr = wr_addr_r;
        mem_wdata = mem_q_r;
        if (idx_r == AW'(COPY_LAST)) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = wr_addr_r;
        mem_wdata = mem_q_r;
        idx_nxt   = AW'(LAST_ROW_BASE);
        state_nxt = S_BLANK;
      end
      S_BLANK: begin
        mem_we = 1'b1;
        if (idx_r == AW'(LAST_CELL)) begin
          state_nxt = S_RESP;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      color_r     <= COLOR_RESET;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      wr_pend_r   <= (state_r == S_COPY);
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        color_r <= cfg_text_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= idx_r;
    data_r    <= data_nxt;
    if (in_valid && in_ready) begin
      op_r <= in_operation;
      ch_r <= in_char_code;
      rr_r <= in_read_row;
      rc_r <= in_read_column;
    end
    if (out_load) begin
      out_cell_r <= data_r;
      out_row_r  <= cur_row_r;
      out_col_r  <= cur_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_data     = out_cell_r;
  assign out_cursor_row    = ROW_FIELD_W'(out_row_r);
  assign out_cursor_column = COL_FIELD_W'(out_col_r);

  `TTCW_ASSERT_NOW(a_cursor_range, 1'b1, (int'(cur_row_r) < ROWS) && (int'(cur_col_r) < COLUMNS))
  `TTCW_ASSERT_NOW(a_mem_no_collide, mem_we && mem_re, mem_waddr != mem_raddr)
  `TTCW_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_r == S_EXEC)
  `TTCW_ASSERT_NEXT(a_drain_blank, state_r == S_DRAIN, (state_r == S_BLANK) && (idx_r == AW'(LAST_ROW_BASE)))

endmodule
